[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the congestion window block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[sv/tcpcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcpcw_pkg
// Types, codes and constants shared by the congestion window core and its
// iterative divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcpcw_pkg;

   localparam int DATA_W    = 32;
   localparam int SEG_W     = 16;
   localparam int PROD_W    = DATA_W + SEG_W;
   localparam int DIV_CNT_W = $clog2(DATA_W);

   // Request modes.
   localparam logic [1:0] MODE_ACK  = 2'd0;
   localparam logic [1:0] MODE_LOSS = 2'd1;
   localparam logic [1:0] MODE_LOAD = 2'd2;

   // Segment size after reset.
   localparam logic [SEG_W-1:0] SEG_SIZE_RESET = 16'd536;

   typedef struct packed {
      logic [1:0]        mode;
      logic [SEG_W-1:0]  acked_segs;
      logic [DATA_W-1:0] load_window;
      logic [DATA_W-1:0] load_threshold;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] window;
      logic [DATA_W-1:0] threshold;
      logic              in_slow_start;
      logic [DATA_W-1:0] ack_credit;
   } rsp_type;

   // Divider status seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SS_MUL,
      ST_CA_DIV_W,
      ST_CA_DIV_CREDIT,
      ST_CA_MUL,
      ST_ADD,
      ST_RESULT
   } state_type;

endpackage

[sv/tcpcw_div.sv]
// ----------------------------------------------------------------------------
// tcpcw_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient and
// remainder hold their values until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcpcw_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tcpcw_pkg::DATA_W-1:0]      dividend,
   input  logic [tcpcw_pkg::DATA_W-1:0]      divisor,
   output logic [tcpcw_pkg::DATA_W-1:0]      quotient,
   output logic [tcpcw_pkg::DATA_W-1:0]      remainder,
   output tcpcw_pkg::div_status_type         status
);
   import tcpcw_pkg::*;

   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    dvsr_ff, dvsr_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DATA_W:0]      shifted;
   logic [DATA_W:0]      diff;

   // One restoring step: shift in the next dividend bit and try to subtract.
   always_comb begin
      shifted  = {rem_ff, quo_ff[DATA_W-1]};
      diff     = shifted - {1'b0, dvsr_ff};
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dvsr_in  = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         count_in = count_ff + DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `ASSERT_ALWAYS(a_start_busy, clock, reset, start |=> busy_ff, "divider did not start")
   `ASSERT_NEVER(a_done_busy, clock, reset, done_ff && busy_ff, "done while busy")
   `ASSERT_ALWAYS(a_rem_small, clock, reset, done_ff |-> (rem_ff < dvsr_ff),
      "remainder not below divisor")

endmodule

[sv/tcp_congestion_window_update_core.sv]
// ----------------------------------------------------------------------------
// tcp_congestion_window_update_core
// TCP congestion window: window, slow-start threshold and ack credit,
// updated one request at a time by a small sequencer around a shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one request per handshake (ack, loss or load). req_ready is high
//            only while the sequencer is idle.
//   rsp_*  : one result per request, the state after that request. It sits in
//            an output register; the next request is accepted while it waits.
//   csr_*  : write of the segment size, always ready.
// Steps, from the edge that accepts a request to the first edge at which
// its result can be taken:
//   load, loss and unused modes: straight to the result stage.
//   ack in slow start: multiply, saturating add and clamp.
//   ack in congestion avoidance: two passes through the 32-bit restoring
//   divider (window in segments, then credit over it), multiply and add,
//   or one pass when the credit stays below the window in segments.
// The next request is accepted at the edge where the result can first be
// taken, so a new request waits until the last one has reached its result.
// Reset: window 0, threshold all ones, credit 0, segment size 536.
// When the receiver stalls, the result holds and one further request can
// complete up to its result stage, where it waits for the register to free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcp_congestion_window_update_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tcpcw_pkg::req_type             req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tcpcw_pkg::rsp_type             rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tcpcw_pkg::SEG_W-1:0]    csr_wdata
);
   import tcpcw_pkg::*;

   state_type           state_ff, state_in;
   logic [SEG_W-1:0]    seg_ff, seg_in;
   logic [DATA_W-1:0]   cwnd_ff, cwnd_in;
   logic [DATA_W-1:0]   ssth_ff, ssth_in;
   logic [DATA_W-1:0]   credit_ff, credit_in;
   logic [SEG_W-1:0]    acked_ff, acked_in;
   logic                ss_ff, ss_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                div_start;
   logic [DATA_W-1:0]   div_dividend;
   logic [DATA_W-1:0]   div_divisor;
   logic [DATA_W-1:0]   div_quotient;
   logic [DATA_W-1:0]   div_remainder;
   div_status_type      div_status;

   logic                below;
   logic                out_free;
   logic [SEG_W-1:0]    seg_div;
   logic [DATA_W-1:0]   w_eff;
   logic [DATA_W:0]     credit_sum;
   logic [DATA_W-1:0]   credit_sat;
   logic [DATA_W-1:0]   two_seg;
   logic [DATA_W-1:0]   half_cwnd;
   logic [DATA_W-1:0]   mul_a;
   logic [PROD_W:0]     grow_sum;
   logic [DATA_W-1:0]   grown;

   // Shared helpers for the datapath.
   assign below      = cwnd_ff < ssth_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign seg_div    = (seg_ff == '0) ? SEG_W'(1) : seg_ff;
   assign w_eff      = (div_quotient == '0) ? DATA_W'(1) : div_quotient;
   assign credit_sum = {1'b0, credit_ff} +
                       {{(DATA_W-SEG_W+1){1'b0}}, req_payload.acked_segs};
   assign credit_sat = credit_sum[DATA_W] ? '1 : credit_sum[DATA_W-1:0];
   assign two_seg    = {{(DATA_W-SEG_W-1){1'b0}}, seg_ff, 1'b0};
   assign half_cwnd  = {1'b0, cwnd_ff[DATA_W-1:1]};
   assign mul_a      = (state_ff == ST_CA_MUL) ? div_quotient
                                               : {{(DATA_W-SEG_W){1'b0}}, acked_ff};
   assign grow_sum   = {{(PROD_W-DATA_W+1){1'b0}}, cwnd_ff} + {1'b0, prod_ff};
   assign grown      = (grow_sum[PROD_W:DATA_W] != '0) ? '1 : grow_sum[DATA_W-1:0];

   // The shared divider.
   tcpcw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.mode == MODE_ACK) begin
                  state_in = below ? ST_SS_MUL : ST_CA_DIV_W;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_SS_MUL: begin
            state_in = ST_ADD;
         end
         ST_CA_DIV_W: begin
            if (div_status.done) begin
               state_in = (credit_ff >= w_eff) ? ST_CA_DIV_CREDIT : ST_RESULT;
            end
         end
         ST_CA_DIV_CREDIT: begin
            if (div_status.done) begin
               state_in = ST_CA_MUL;
            end
         end
         ST_CA_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath controls and register next values.
   always_comb begin
      cwnd_in      = cwnd_ff;
      ssth_in      = ssth_ff;
      credit_in    = credit_ff;
      acked_in     = acked_ff;
      ss_in        = ss_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_start    = 1'b0;
      div_dividend = cwnd_ff;
      div_divisor  = {{(DATA_W-SEG_W){1'b0}}, seg_div};
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               acked_in = req_payload.acked_segs;
               case (req_payload.mode)
                  MODE_ACK: begin
                     ss_in = below;
                     if (!below) begin
                        credit_in = credit_sat;
                        div_start = 1'b1;
                     end
                  end
                  MODE_LOSS: begin
                     ssth_in = (two_seg > half_cwnd) ? two_seg : half_cwnd;
                  end
                  MODE_LOAD: begin
                     cwnd_in = req_payload.load_window;
                     ssth_in = req_payload.load_threshold;
                  end
                  default: begin
                     ss_in = ss_ff;
                  end
               endcase
            end
         end
         ST_CA_DIV_W: begin
            if (div_status.done) begin
               if (credit_ff >= w_eff) begin
                  div_start    = 1'b1;
                  div_dividend = credit_ff;
                  div_divisor  = w_eff;
               end
            end
         end
         ST_CA_DIV_CREDIT: begin
            if (div_status.done) begin
               credit_in = div_remainder;
            end
         end
         ST_SS_MUL, ST_CA_MUL: begin
            prod_in = PROD_W'(mul_a) * PROD_W'(seg_ff);
         end
         ST_ADD: begin
            if (ss_ff && (grown >= ssth_ff)) begin
               cwnd_in = ssth_ff;
            end else begin
               cwnd_in = grown;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.window        = cwnd_ff;
               rsp_in.threshold     = ssth_ff;
               rsp_in.in_slow_start = below;
               rsp_in.ack_credit    = credit_ff;
            end
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   // Configuration register: written whenever offered.
   assign csr_ready = 1'b1;
   assign seg_in    = csr_valid ? csr_wdata : seg_ff;

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_ff       <= SEG_SIZE_RESET;
         cwnd_ff      <= '0;
         ssth_ff      <= '1;
         credit_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         cwnd_ff      <= cwnd_in;
         ssth_ff      <= ssth_in;
         credit_ff    <= credit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of one request.
   always_ff @(posedge clock) begin
      acked_ff <= acked_in;
      ss_ff    <= ss_in;
      prod_ff  <= prod_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_NEVER(a_start_while_busy, clock, reset, div_start && div_status.busy,
      "divider restarted while busy")
   `ASSERT_ALWAYS(a_div_wait, clock, reset,
      ((state_ff == ST_CA_DIV_W) || (state_ff == ST_CA_DIV_CREDIT)) |->
      (div_status.busy || div_status.done), "waiting on an idle divider")
   `ASSERT_ALWAYS(a_ss_clamp, clock, reset,
      ((state_ff == ST_ADD) && ss_ff) |=> (cwnd_ff <= ssth_ff),
      "slow start grew past the threshold")

endmodule
